// ----- hdl/ure_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ure_pkg;

    localparam int TICK_W    = 16;
    localparam int BIT_IDX_W = 4;
    localparam int BYTE_W    = 8;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_ECHO  = 2'd3
    } phase_t;

    typedef struct packed {
        logic              tx_line;
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_value;
        logic              stop_error;
        logic              echo_busy;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/ure_frame.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ure_frame
    import ure_pkg::*;
#(
    parameter int DATA_BITS = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire logic              rx_bit,
    input  wire logic [TICK_W-1:0] period_cfg,
    output result_t                res
);

    localparam logic [BIT_IDX_W-1:0] LastData = BIT_IDX_W'(DATA_BITS);
    localparam logic [BIT_IDX_W-1:0] StopIdx  = BIT_IDX_W'(DATA_BITS + 1);

    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_count_reg, tick_count_next;
    logic [BIT_IDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0]     shift_byte_reg, shift_byte_next;
    logic                  tx_level_reg, tx_level_next;

    logic [TICK_W-1:0]     period;
    logic [TICK_W-1:0]     tick_inc;
    logic                  half_hit;
    logic                  bit_hit;
    logic [BIT_IDX_W-1:0]  echo_idx;
    logic [BIT_IDX_W-1:0]  echo_pos;

    assign period   = (period_cfg == '0) ? TICK_W'(1) : period_cfg;
    assign tick_inc = tick_count_reg + TICK_W'(1);
    assign half_hit = (tick_inc >= (period_cfg >> 1));
    assign bit_hit  = (tick_inc >= period);
    assign echo_idx = bit_index_reg + BIT_IDX_W'(1);
    assign echo_pos = echo_idx - BIT_IDX_W'(1);

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!rx_bit)
                begin
                    phase_next = PH_START;
                end
            end
            PH_START:
            begin
                if (half_hit)
                begin
                    phase_next = rx_bit ? PH_IDLE : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (bit_hit && (bit_index_reg >= LastData))
                begin
                    phase_next = rx_bit ? PH_ECHO : PH_IDLE;
                end
            end
            PH_ECHO:
            begin
                if (bit_hit && (echo_idx != StopIdx)
                    && !((echo_idx >= BIT_IDX_W'(1)) && (echo_idx <= LastData)))
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        tx_level_next   = tx_level_reg;
        res.tx_line     = tx_level_reg;
        res.echo_busy   = (phase_reg == PH_ECHO);
        res.byte_valid  = 1'b0;
        res.byte_value  = '0;
        res.stop_error  = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!rx_bit)
                begin
                    tick_count_next = '0;
                end
            end
            PH_START:
            begin
                tick_count_next = tick_inc;
                if (half_hit)
                begin
                    tick_count_next = '0;
                    if (!rx_bit)
                    begin
                        bit_index_next  = '0;
                        shift_byte_next = '0;
                    end
                end
            end
            PH_DATA:
            begin
                tick_count_next = tick_inc;
                if (bit_hit)
                begin
                    tick_count_next = '0;
                    if (bit_index_reg < LastData)
                    begin
                        if (bit_index_reg < BIT_IDX_W'(BYTE_W))
                        begin
                            shift_byte_next[bit_index_reg[2:0]] = rx_bit;
                        end
                        bit_index_next = bit_index_reg + BIT_IDX_W'(1);
                    end
                    else if (!rx_bit)
                    begin
                        res.stop_error = 1'b1;
                        bit_index_next = '0;
                    end
                    else
                    begin
                        res.byte_valid = 1'b1;
                        res.byte_value = shift_byte_reg;
                        bit_index_next = '0;
                        tx_level_next  = 1'b0;
                    end
                end
            end
            PH_ECHO:
            begin
                tick_count_next = tick_inc;
                if (bit_hit)
                begin
                    tick_count_next = '0;
                    bit_index_next  = echo_idx;
                    if ((echo_idx >= BIT_IDX_W'(1)) && (echo_idx <= LastData))
                    begin
                        tx_level_next = (echo_pos < BIT_IDX_W'(BYTE_W))
                                        ? shift_byte_reg[echo_pos[2:0]] : 1'b0;
                    end
                    else if (echo_idx == StopIdx)
                    begin
                        tx_level_next = 1'b1;
                    end
                    else
                    begin
                        tx_level_next  = 1'b1;
                        bit_index_next = '0;
                    end
                end
            end
            default:
            begin
                tick_count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            tx_level_reg   <= 1'b1;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            tx_level_reg   <= tx_level_next;
        end
    end

`ifndef SYNTHESIS
    a_valid_error_excl: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |-> !(res.byte_valid && res.stop_error))
        else $error("byte_valid and stop_error together");

    a_good_byte_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.byte_valid) |=> (phase_reg == PH_ECHO) && !tx_level_reg)
        else $error("good frame did not start echo");

    a_tx_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_ECHO) |-> tx_level_reg)
        else $error("tx line low outside echo");

    a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= StopIdx)
        else $error("bit index out of range");
`endif

endmodule

`default_nettype wire

// ----- hdl/ure_out_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ure_out_reg
    import ure_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res_in,
    input  wire logic    out_stall,
    output logic         can_load,
    output logic         out_valid,
    output result_t      res_out
);

    logic    vld_reg, vld_next;
    result_t res_reg;

    assign can_load  = !vld_reg || !out_stall;
    assign vld_next  = load || (vld_reg && out_stall);
    assign out_valid = vld_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && out_stall) |-> !load)
        else $error("pending result overwritten");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && out_stall) |=> vld_reg && $stable(res_reg))
        else $error("stalled result changed");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> vld_reg)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ----- hdl/uart_8n1_receive_and_echo_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// UART 8N1 receiver with echo: one sample of the receive line per transaction on the
// input channel and one result per transaction on the output channel. An item passes
// through the input register and then the result register, and a new sample is taken
// every cycle while the output is not stalled; the frame state updates once per item in
// a single pass between those two registers. bit_period_ticks is the number of samples
// per bit time and is written through the configuration channel, which is always
// ready; write it only while no item is in flight.

module uart_8n1_receive_and_echo_core
    import ure_pkg::*;
#(
    parameter int DATA_BITS = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [TICK_W-1:0] bit_period_ticks,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              rx_level,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   tx_line,
    output logic                   byte_valid,
    output logic [BYTE_W-1:0]      byte_value,
    output logic                   stop_error,
    output logic                   echo_busy
);

    localparam logic [TICK_W-1:0] PeriodReset = TICK_W'(2604);

    logic [TICK_W-1:0] period_reg;
    logic              in_vld_reg, in_vld_next;
    logic              rx_reg;
    logic              can_load;
    logic              step_en;
    logic              in_take;
    result_t           res_step;
    result_t           res_out;

    assign cfg_ready   = 1'b1;
    assign step_en     = in_vld_reg && can_load;
    assign in_stall    = in_vld_reg && !can_load;
    assign in_take     = in_valid && !in_stall;
    assign in_vld_next = in_take || (in_vld_reg && !step_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PeriodReset;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= bit_period_ticks;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rx_reg <= rx_level;
        end
    end

    ure_frame #(
        .DATA_BITS (DATA_BITS)
    ) u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .rx_bit     (rx_reg),
        .period_cfg (period_reg),
        .res        (res_step)
    );

    ure_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_en),
        .res_in    (res_step),
        .out_stall (out_stall),
        .can_load  (can_load),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign tx_line    = res_out.tx_line;
    assign byte_valid = res_out.byte_valid;
    assign byte_value = res_out.byte_value;
    assign stop_error = res_out.stop_error;
    assign echo_busy  = res_out.echo_busy;

`ifndef SYNTHESIS
    a_in_reg_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !step_en) |=> in_vld_reg && $stable(rx_reg))
        else $error("waiting sample lost");

    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |-> (!out_valid || !out_stall))
        else $error("step with full result register");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_valid && out_stall)
        else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire
